[src/oneshot_timer_timespec_macros.svh]
// Assertion macros for the one-shot timer checker.
// Used by the checker only; holds no logic of its own.
`ifndef ONESHOT_TIMER_TIMESPEC_MACROS_SVH
`define ONESHOT_TIMER_TIMESPEC_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define OTTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("otts: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent
`define OTTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("otts: next-cycle property failed");

`endif

[src/otts_pkg.sv]
// Package for the one-shot timer: widths, constants, codes and unit interface types.
// No dependencies; used by every other file of the block but the macro header.
`timescale 1ns / 1ps
`default_nettype none

package otts_pkg;

    // serial unit sizes
    localparam int MUL_W     = 32;
    localparam int MUL_CNT_W = $clog2(MUL_W);
    localparam int DIV_W     = 64;
    localparam int DIVR_W    = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // field widths
    localparam int SEC_IN_W  = 32;
    localparam int NS_W      = 30;
    localparam int CNT_W     = 64;

    localparam logic [31:0] TICK_RATE_RESET = 32'd24_000_000;
    localparam logic [31:0] NS_PER_SEC      = 32'd1_000_000_000;
    localparam logic [31:0] MAX_REL         = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_ENABLE = 1'd1;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_START  = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] mcand;
        logic [MUL_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quotient;
        logic [DIVR_W-1:0] remainder;
    } div_res_t;

endpackage

`default_nettype wire

[src/oneshot_timer_timespec.sv]
// Top level of the one-shot timer: sequencer, timer state and output register.
// Depends on otts_pkg, otts_mul and otts_div.
//
// Usage: one item per transfer on the s_ channel; s_tuser carries the mode
// (tick, start, cancel, read), s_tdata the delay for start. Every item gives
// exactly one result on the m_ channel: the expiry flag for a tick, the
// counter as seconds and nanoseconds for a read, zeros otherwise.
// Items are handled one at a time. A tick or cancel goes straight to the
// hand-over state; a start runs two serial multiplies and a serial divide,
// and a read runs two serial divides and one serial multiply, on the shared
// bit-serial multiplier and divider.
// The result sits in an output register, so a new item is taken while a
// finished result waits; if the receiver stalls, the next finished result
// holds inside until the output register frees, and s_tready stays low.
// Reset (aresetn, synchronous, active low) clears the counter and compare
// value, masks the interrupt, disarms, and loads tick_rate 24000000 and
// timer_enable 1. Configuration is written through cfg_we/cfg_index/cfg_wdata
// by the user, only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module oneshot_timer_timespec (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,  // seconds_in[31:0], nanoseconds_in[61:32]
    input  wire logic [1:0]                     s_tuser,  // mode[1:0]
    // result channel
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [95:0]                         m_tdata,  // expired[0], seconds_out[64:1],
                                                          // nanoseconds_out[94:65]
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [otts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_wdata
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL_SEC = 9'b000000010,
        ST_MUL_NS  = 9'b000000100,
        ST_DIV_NS  = 9'b000001000,
        ST_SUM     = 9'b000010000,
        ST_DIV_CNT = 9'b000100000,
        ST_MUL_REM = 9'b001000000,
        ST_DIV_REM = 9'b010000000,
        ST_FIN     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [31:0] tick_rate_reg;
    logic        timer_enable_reg;
    logic [31:0] rate_eff;

    // timer state
    logic [otts_pkg::CNT_W-1:0] counter_reg, counter_next;
    logic [otts_pkg::CNT_W-1:0] compare_reg, compare_next;
    logic                       masked_reg, masked_next;
    logic                       armed_reg, armed_next;

    // working registers
    logic [otts_pkg::NS_W-1:0]  nsec_reg, nsec_next;
    logic [otts_pkg::CNT_W-1:0] ticks_reg, ticks_next;
    logic [31:0]                rel_reg, rel_next;

    // pending result
    logic                       res_exp_reg, res_exp_next;
    logic [otts_pkg::CNT_W-1:0] res_sec_reg, res_sec_next;
    logic [otts_pkg::NS_W-1:0]  res_ns_reg, res_ns_next;

    // output register
    logic                       m_valid_reg, m_valid_next;
    logic                       m_exp_reg, m_exp_next;
    logic [otts_pkg::CNT_W-1:0] m_sec_reg, m_sec_next;
    logic [otts_pkg::NS_W-1:0]  m_ns_reg, m_ns_next;

    // serial units
    otts_pkg::mul_req_t         mul_req;
    logic                       mul_done;
    logic [otts_pkg::CNT_W-1:0] mul_prod;
    otts_pkg::div_req_t         div_req;
    otts_pkg::div_res_t         div_res;

    // input fields
    otts_pkg::mode_t                in_mode;
    logic [otts_pkg::SEC_IN_W-1:0]  in_sec;
    logic [otts_pkg::NS_W-1:0]      in_nsec;

    logic [otts_pkg::CNT_W-1:0] counter_inc;
    logic                       fire;
    logic [otts_pkg::CNT_W:0]   rel_wide;

    assign in_mode = otts_pkg::mode_t'(s_tuser);
    assign in_sec  = s_tdata[31:0];
    assign in_nsec = s_tdata[61:32];

    // a zero rate counts as one tick per second
    assign rate_eff = (tick_rate_reg == '0) ? 32'd1 : tick_rate_reg;

    // tick: advance first, then compare against the new count
    assign counter_inc = counter_reg + 1'b1;
    assign fire        = timer_enable_reg && !masked_reg && (counter_inc >= compare_reg);

    // whole-second ticks plus the nanosecond share
    assign rel_wide = {1'b0, ticks_reg} + {1'b0, div_res.quotient};

    assign s_tready = (state_reg == ST_IDLE);

    otts_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    otts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        counter_next = counter_reg;
        compare_next = compare_reg;
        masked_next  = masked_reg;
        armed_next   = armed_reg;
        nsec_next    = nsec_reg;
        ticks_next   = ticks_reg;
        rel_next     = rel_reg;
        res_exp_next = res_exp_reg;
        res_sec_next = res_sec_reg;
        res_ns_next  = res_ns_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_exp_next   = m_exp_reg;
        m_sec_next   = m_sec_reg;
        m_ns_next    = m_ns_reg;
        mul_req      = '0;
        div_req      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_exp_next = 1'b0;
                    res_sec_next = '0;
                    res_ns_next  = '0;
                    nsec_next    = in_nsec;
                    case (in_mode)
                        otts_pkg::MODE_TICK: begin
                            counter_next = counter_inc;
                            if (fire) begin
                                masked_next  = 1'b1;
                                res_exp_next = armed_reg;
                            end
                            state_next = ST_FIN;
                        end
                        otts_pkg::MODE_START: begin
                            mul_req.start  = 1'b1;
                            mul_req.mcand  = rate_eff;
                            mul_req.mplier = in_sec;
                            state_next     = ST_MUL_SEC;
                        end
                        otts_pkg::MODE_CANCEL: begin
                            masked_next = 1'b1;
                            armed_next  = 1'b0;
                            state_next  = ST_FIN;
                        end
                        otts_pkg::MODE_READ: begin
                            div_req.start    = 1'b1;
                            div_req.dividend = counter_reg;
                            div_req.divisor  = rate_eff;
                            state_next       = ST_DIV_CNT;
                        end
                        default: state_next = ST_FIN;
                    endcase
                end
            end
            // start: seconds * rate
            ST_MUL_SEC: begin
                if (mul_done) begin
                    ticks_next     = mul_prod;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = rate_eff;
                    mul_req.mplier = {{(otts_pkg::MUL_W-otts_pkg::NS_W){1'b0}}, nsec_reg};
                    state_next     = ST_MUL_NS;
                end
            end
            // start: nanoseconds * rate, then divide by 1e9
            ST_MUL_NS: begin
                if (mul_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_prod;
                    div_req.divisor  = otts_pkg::NS_PER_SEC;
                    state_next       = ST_DIV_NS;
                end
            end
            // start: saturate the relative delay
            ST_DIV_NS: begin
                if (div_res.done) begin
                    rel_next   = (rel_wide[otts_pkg::CNT_W:32] != '0) ?
                                 otts_pkg::MAX_REL : rel_wide[31:0];
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                compare_next = counter_reg + {32'b0, rel_reg};
                masked_next  = 1'b0;
                armed_next   = 1'b1;
                state_next   = ST_FIN;
            end
            // read: whole seconds, then scale the remainder
            ST_DIV_CNT: begin
                if (div_res.done) begin
                    res_sec_next   = div_res.quotient;
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = div_res.remainder;
                    mul_req.mplier = otts_pkg::NS_PER_SEC;
                    state_next     = ST_MUL_REM;
                end
            end
            ST_MUL_REM: begin
                if (mul_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = mul_prod;
                    div_req.divisor  = rate_eff;
                    state_next       = ST_DIV_REM;
                end
            end
            // quotient stays below 1e9, so the low bits hold it all
            ST_DIV_REM: begin
                if (div_res.done) begin
                    res_ns_next = div_res.quotient[otts_pkg::NS_W-1:0];
                    state_next  = ST_FIN;
                end
            end
            // hand over to the output register once it is free
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_exp_next   = res_exp_reg;
                    m_sec_next   = res_sec_reg;
                    m_ns_next    = res_ns_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tick_rate_reg    <= otts_pkg::TICK_RATE_RESET;
            timer_enable_reg <= 1'b1;
            counter_reg      <= '0;
            compare_reg      <= '0;
            masked_reg       <= 1'b1;
            armed_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            compare_reg <= compare_next;
            masked_reg  <= masked_next;
            armed_reg   <= armed_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    otts_pkg::REG_TICK_RATE:    tick_rate_reg    <= cfg_wdata;
                    otts_pkg::REG_TIMER_ENABLE: timer_enable_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        nsec_reg    <= nsec_next;
        ticks_reg   <= ticks_next;
        rel_reg     <= rel_next;
        res_exp_reg <= res_exp_next;
        res_sec_reg <= res_sec_next;
        res_ns_reg  <= res_ns_next;
        m_exp_reg   <= m_exp_next;
        m_sec_reg   <= m_sec_next;
        m_ns_reg    <= m_ns_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_ns_reg, m_sec_reg, m_exp_reg};

endmodule

`default_nettype wire

[src/otts_mul.sv]
// Bit-serial shift-add multiplier, 32 x 32 -> 64, one multiplier bit per cycle.
// Depends on otts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otts_mul (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire otts_pkg::mul_req_t              req,
    output logic                                 done,
    output logic [2*otts_pkg::MUL_W-1:0]         product
);

    logic [otts_pkg::MUL_W-1:0]     mcand_reg, mcand_next;
    logic [otts_pkg::MUL_W-1:0]     hi_reg, hi_next;
    logic [otts_pkg::MUL_W-1:0]     lo_reg, lo_next;
    logic [otts_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [otts_pkg::MUL_W:0]       partial;

    // add the multiplicand when the current multiplier bit is set
    assign partial = {1'b0, hi_reg} +
                     (lo_reg[0] ? {1'b0, mcand_reg} : {(otts_pkg::MUL_W+1){1'b0}});

    always_comb begin
        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            mcand_next = req.mcand;
            hi_next    = '0;
            lo_next    = req.mplier;
            cnt_next   = otts_pkg::MUL_CNT_W'(otts_pkg::MUL_W - 1);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            // shift the sum down one place, low bit enters the multiplier word
            hi_next  = partial[otts_pkg::MUL_W:1];
            lo_next  = {partial[0], lo_reg[otts_pkg::MUL_W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        cnt_reg   <= cnt_next;
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

`default_nettype wire

[src/otts_div.sv]
// Restoring divider, 64 / 32 -> 64 quotient and 32 remainder, one quotient bit per cycle.
// Depends on otts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otts_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire otts_pkg::div_req_t req,
    output otts_pkg::div_res_t      res
);

    logic [otts_pkg::DIVR_W-1:0]    dvs_reg, dvs_next;
    logic [otts_pkg::DIVR_W-1:0]    rem_reg, rem_next;
    logic [otts_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [otts_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [otts_pkg::DIVR_W:0]      trial;
    logic [otts_pkg::DIVR_W+1:0]    diff;
    logic                           qbit;

    // bring down the next dividend bit and try the subtraction
    assign trial = {rem_reg, quo_reg[otts_pkg::DIV_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign qbit  = ~diff[otts_pkg::DIVR_W+1];

    always_comb begin
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvs_next  = req.divisor;
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = otts_pkg::DIV_CNT_W'(otts_pkg::DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits the narrow word
            rem_next = qbit ? diff[otts_pkg::DIVR_W-1:0] : trial[otts_pkg::DIVR_W-1:0];
            quo_next = {quo_reg[otts_pkg::DIV_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

`default_nettype wire

[src/otts_checker.sv]
// Port-level checker for the one-shot timer, bound to the top level.
// Depends on otts_pkg and oneshot_timer_timespec_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "oneshot_timer_timespec_macros.svh"

module otts_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // a stalled result holds
    `OTTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // one item at a time: ready drops after every transfer
    `OTTS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // nanosecond part is always below one second
    `OTTS_ASSERT_SAME(a_ns_range, aclk, aresetn, m_tvalid, m_tdata[94:65] < otts_pkg::NS_PER_SEC[29:0])

    // an expiry result carries no time
    `OTTS_ASSERT_SAME(a_exp_no_time, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[94:1] == '0)

endmodule

bind oneshot_timer_timespec otts_checker u_otts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/oneshot_timer_timespec_tb.sv]
// Self-checking testbench for the one-shot timer: a directed table, then random phases
// under different tick rates and enable settings, scored against a behavioural predictor.
// Depends on otts_pkg and oneshot_timer_timespec.
`timescale 1ns / 1ps

module oneshot_timer_timespec_tb;
    import otts_pkg::*;

    localparam int        CYCLE_LIMIT   = 1_000_000;
    localparam int        PHASE_ITEMS   = 50;
    localparam int        NUM_PHASES    = 8;
    localparam int        NUM_DIRECTED  = 31;
    localparam int        SETTLE_CYCLES = 4;
    localparam logic [63:0] NS_SEC_64   = {32'd0, NS_PER_SEC};

    typedef struct packed {
        logic             expired;
        logic [63:0]      secs;
        logic [NS_W-1:0]  nsecs;
    } timer_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one row of the directed table; ROW_CFG rows only use rate/enable
    typedef struct packed {
        row_kind_t           kind;
        mode_t               mode;
        logic [31:0]         sec;
        logic [NS_W-1:0]     ns;
        logic [31:0]         rate;
        logic                enable;
        logic                typed;
        timer_result_t       result;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // seconds_in[31:0], nanoseconds_in[61:32], zero[63:62]
    logic [1:0]   s_tuser;   // mode[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;   // expired[0], seconds_out[64:1], nanoseconds_out[94:65]
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_wdata;

    // timer state as the predictor sees it
    logic [31:0] model_rate;
    logic        model_enable;
    logic [63:0] model_count;
    logic [63:0] model_compare;
    logic        model_masked;
    logic        model_armed;

    timer_result_t pending_results[$];
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  results_seen   = 0;
    int  expiries_seen  = 0;
    int  reads_sent     = 0;
    int  settings_used  = 0;
    int  cycle_count    = 0;
    bit  bursts_on      = 1'b1;

    // directed table: reset values, zero delay, expiry, saturation, zero rate, disable
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{ROW_CFG,  MODE_TICK,   32'd0,         30'd0,         32'd4, 1'b1, 1'b0, '0},
        '{ROW_ITEM, MODE_READ,   32'd0,         30'd0,         32'd0, 1'b0, 1'b1,
          '{1'b0, 64'd0, 30'd0}},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b1, '0},
        '{ROW_ITEM, MODE_CANCEL, 32'd0,         30'd0,         32'd0, 1'b0, 1'b1, '0},
        '{ROW_ITEM, MODE_START,  32'd0,         30'd0,         32'd0, 1'b0, 1'b1, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b1,
          '{1'b1, 64'd0, 30'd0}},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b1, '0},
        '{ROW_ITEM, MODE_READ,   32'd0,         30'd0,         32'd0, 1'b0, 1'b1,
          '{1'b0, 64'd0, 30'd750000000}},
        '{ROW_ITEM, MODE_START,  32'd1,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_START,  32'd0,         30'd999999999, 32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_CANCEL, 32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_START,  32'hFFFFFFFF,  30'h3FFFFFFF,  32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_READ,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b1, 1'b0, '0},
        '{ROW_ITEM, MODE_READ,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_START,  32'd2,         30'h3FFFFFFF,  32'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_CFG,  MODE_TICK,   32'd0,         30'd0,         32'hFFFFFFFF, 1'b1, 1'b0, '0},
        '{ROW_ITEM, MODE_START,  32'd0,         30'd1,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_TICK,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, MODE_READ,   32'd0,         30'd0,         32'd0, 1'b0, 1'b0, '0}
    };

    // tick rate and enable for each random phase; extremes included
    logic [31:0] phase_rate [NUM_PHASES] = '{32'd24000000, 32'd1, 32'd3, 32'd0,
                                             32'd7, 32'hFFFFFFFF, 32'd1000, 32'd5};
    logic        phase_en   [NUM_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1,
                                             1'b0, 1'b1, 1'b1, 1'b1};

    oneshot_timer_timespec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the timer state by one item and return the result it produces
    function automatic timer_result_t timer_advance(input mode_t mode, input logic [31:0] sec,
                                                    input logic [NS_W-1:0] ns);
        timer_result_t r;
        logic [63:0]   rate;
        logic [63:0]   whole;
        logic [63:0]   frac;
        logic [63:0]   total;
        r    = '0;
        rate = (model_rate == 32'd0) ? 64'd1 : {32'd0, model_rate};
        case (mode)
            MODE_TICK: begin
                model_count = model_count + 64'd1;
                if (model_enable && !model_masked && model_count >= model_compare) begin
                    model_masked = 1'b1;
                    r.expired    = model_armed;
                end
            end
            MODE_START: begin
                whole = {32'd0, sec} * rate;
                frac  = ({34'd0, ns} * rate) / NS_SEC_64;
                total = whole + frac;
                // relative delay saturates at 32 bits
                if (total < whole || total > {32'd0, MAX_REL})
                    total = {32'd0, MAX_REL};
                model_compare = model_count + total;
                model_masked  = 1'b0;
                model_armed   = 1'b1;
            end
            MODE_CANCEL: begin
                model_masked = 1'b1;
                model_armed  = 1'b0;
            end
            default: begin
                r.secs = model_count / rate;
                frac   = ((model_count % rate) * NS_SEC_64) / rate;
                r.nsecs = frac[NS_W-1:0];
            end
        endcase
        return r;
    endfunction

    // Present one item, wait for its transfer, queue what it should produce, and at times pause the input
    task automatic send_item(input mode_t mode, input logic [31:0] sec,
                             input logic [NS_W-1:0] ns, input logic typed,
                             input timer_result_t typed_res);
        timer_result_t r;
        int            gap;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, ns, sec};
        do @(posedge aclk); while (!s_tready);
        r = timer_advance(mode, sec, ns);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
        if (mode == MODE_READ)
            reads_sent++;
        gap = (bursts_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender until every queued result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the tick rate register, then the timer enable register, and updates the predictor
    task automatic write_config(input logic [31:0] rate, input logic en);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TICK_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_index <= REG_TIMER_ENABLE;
        cfg_wdata <= {31'd0, en};
        @(posedge aclk);
        cfg_we       <= 1'b0;
        model_rate   = rate;
        model_enable = en;
        settings_used++;
    endtask

    // Stimulus
    initial begin
        mode_t       mode;
        logic [31:0] sec;
        logic [29:0] ns;
        logic [63:0] eff_rate;
        logic [63:0] ns_lim;
        int          pick;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_TICK;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_TICK_RATE;
        cfg_wdata <= '0;

        model_rate    = TICK_RATE_RESET;
        model_enable  = 1'b1;
        model_count   = '0;
        model_compare = '0;
        model_masked  = 1'b1;
        model_armed   = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                drain_results();
                write_config(directed_rows[i].rate, directed_rows[i].enable);
            end else begin
                send_item(directed_rows[i].mode, directed_rows[i].sec, directed_rows[i].ns,
                          directed_rows[i].typed, directed_rows[i].result);
            end
        end

        // random phases, one timer setting each; the third, the sixth and the last run without idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            write_config(phase_rate[ph], phase_en[ph]);
            bursts_on = (ph != NUM_PHASES - 1) && (ph % 3 != 2);
            eff_rate  = (phase_rate[ph] == 32'd0) ? 64'd1 : {32'd0, phase_rate[ph]};
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain_results();
                pick = $urandom_range(0, 99);
                sec  = $urandom;
                ns   = 30'($urandom_range(0, 30'h3FFFFFFF));
                if (pick < 45) begin
                    mode = MODE_TICK;
                end else if (pick < 67) begin
                    mode = MODE_START;
                    // mostly delays short enough that the counter reaches them
                    if ($urandom_range(0, 3) != 0) begin
                        if (eff_rate <= 64'd20) begin
                            sec = $urandom_range(0, 20 / int'(eff_rate));
                        end else begin
                            sec    = 32'd0;
                            ns_lim = (64'd20 * NS_SEC_64) / eff_rate;
                            if (ns_lim > 64'd999999999)
                                ns_lim = 64'd999999999;
                            ns = 30'($urandom_range(0, int'(ns_lim)));
                        end
                    end
                end else if (pick < 76) begin
                    mode = MODE_CANCEL;
                end else if (pick < 95) begin
                    mode = MODE_READ;
                end else begin
                    mode = mode_t'($urandom_range(0, 3));
                end
                send_item(mode, sec, ns, 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge aclk);
        $display("Sent %0d transfers over %0d timer settings, %0d of them time reads",
                 items_sent, settings_used, reads_sent);
        $display("Checked %0d results, %0d of them expiries", results_seen, expiries_seen);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result side: random stalls on m_tready and scoring of each transfer
    always @(posedge aclk) begin
        timer_result_t want;
        int            stall_left;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (want.expired)
                    expiries_seen++;
                if (m_tdata[0] !== want.expired) begin
                    mismatch_count++;
                    $display("%0t: expired expected %0d actual %0d",
                             $time, want.expired, m_tdata[0]);
                end
                if (m_tdata[64:1] !== want.secs) begin
                    mismatch_count++;
                    $display("%0t: seconds_out expected %0d actual %0d",
                             $time, want.secs, m_tdata[64:1]);
                end
                if (m_tdata[94:65] !== want.nsecs) begin
                    mismatch_count++;
                    $display("%0t: nanoseconds_out expected %0d actual %0d",
                             $time, want.nsecs, m_tdata[94:65]);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
